### hdl/dpec_pkg.sv
// Shared types and constants for the disc pair collision pipeline.
`default_nettype none
package dpec_pkg;

	// Velocity word and the four velocity components of a pair
	typedef logic signed [15:0] vel_t;

	typedef struct packed {
		vel_t ax;
		vel_t ay;
		vel_t bx;
		vel_t by;
	} vel4_t;

	typedef enum logic [1:0] {
		ST_APART      = 2'd0,
		ST_SEPARATING = 2'd1,
		ST_RESOLVED   = 2'd2,
		ST_COINCIDENT = 2'd3
	} status_t;

	// Data that rides alongside the dividers
	typedef struct packed {
		vel4_t   vel;
		status_t status;
		logic    neg_x;
		logic    neg_y;
	} side_t;

	// Quotient magnitude stays below 2^18 (Cauchy-Schwarz bound on k*d)
	localparam int DIV_STEPS = 18;
	localparam int NUM_W     = 47;
	localparam int DEN_W     = 29;

	// Stage map: s1..s5, then the divider steps, then the output register
	localparam int DIV_BASE   = 5;
	localparam int STG_OUT    = DIV_BASE + DIV_STEPS;
	localparam int PIPE_DEPTH = STG_OUT + 1;

	localparam logic [7:0] FRAME_RATE_RST = 8'd60;

endpackage
`default_nettype wire

### hdl/dpec_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module dpec_div (
	input  wire logic                             clk,
	input  wire logic [dpec_pkg::DIV_STEPS-1:0]   en,
	input  wire logic [dpec_pkg::NUM_W-1:0]       num,
	input  wire logic [dpec_pkg::DEN_W-1:0]       den,
	output logic      [dpec_pkg::DIV_STEPS-1:0]   quo
);
	import dpec_pkg::*;

	// remainder and divisor only travel between steps, not out of the last one
	logic [NUM_W-1:0]     rem_s [DIV_STEPS-1];
	logic [DEN_W-1:0]     den_s [DIV_STEPS-1];
	logic [DIV_STEPS-1:0] quo_s [DIV_STEPS];

	genvar g;
	generate
		for (g = 0; g < DIV_STEPS; g++) begin : g_step
			localparam int SH = DIV_STEPS - 1 - g;
			logic [NUM_W-1:0]     r_in;
			logic [DEN_W-1:0]     d_in;
			logic [DIV_STEPS-1:0] q_in;
			logic [NUM_W-1:0]     dsh;
			logic                 take;

			if (g == 0) begin : g_first
				assign r_in = num;
				assign d_in = den;
				assign q_in = '0;
			end else begin : g_next
				assign r_in = rem_s[g-1];
				assign d_in = den_s[g-1];
				assign q_in = quo_s[g-1];
			end

			// trial subtract of the shifted divisor
			assign dsh  = {{(NUM_W-DEN_W){1'b0}}, d_in} << SH;
			assign take = (r_in >= dsh);

			always_ff @(posedge clk) begin
				if (en[g]) begin
					quo_s[g] <= {q_in[DIV_STEPS-2:0], take};
				end
			end

			if (g < DIV_STEPS - 1) begin : g_carry
				always_ff @(posedge clk) begin
					if (en[g]) begin
						rem_s[g] <= take ? (r_in - dsh) : r_in;
						den_s[g] <= d_in;
					end
				end
			end
		end
	endgenerate

	assign quo = quo_s[DIV_STEPS-1];

endmodule
`default_nettype wire

### hdl/disc_pair_elastic_collision.sv
// Top level: overlap and approach tests and velocity exchange for a disc pair.
//
//  channel   dir  handshake        payload
//  s_*       in   tvalid/tready    136-bit tdata, one disc pair
//  m_*       out  tvalid/tready    64-bit tdata velocities, 2-bit tuser status
//  cfg_*     in   cfg_we           8-bit frame_rate
//
// One word per cycle unless the output stalls; pipeline of five arithmetic stages, 18 divider
// steps (one quotient bit each) and the output register.
// Reset clears all valid bits and sets frame_rate to 60.
// Each stage loads when it is empty or the next stage loads, so a stalled
// output only backs up through full stages; bubbles are squeezed out.
`default_nettype none
module disc_pair_elastic_collision (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// cfg: frame_rate
	input  wire logic          cfg_we,
	input  wire logic [7:0]    cfg_wdata,
	// tdata: a_pos_x[13:0] a_pos_y[27:14] a_radius[33:28] a_vel_x[49:34]
	//        a_vel_y[65:50] b_pos_x[79:66] b_pos_y[93:80] b_radius[99:94]
	//        b_vel_x[115:100] b_vel_y[131:116], zero fill [135:132]
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [135:0]  s_tdata,
	// tdata: new_a_vel_x[15:0] new_a_vel_y[31:16] new_b_vel_x[47:32]
	//        new_b_vel_y[63:48]
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [63:0]        m_tdata,
	// tuser: status[1:0]
	output logic [1:0]         m_tuser
);
	import dpec_pkg::*;

	// frame rate register
	logic [7:0] frame_rate_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rate_q <= FRAME_RATE_RST;
		end else if (cfg_we) begin
			frame_rate_q <= cfg_wdata;
		end
	end

	// valid bits and per-stage load enables
	logic [PIPE_DEPTH-1:0] vld_s;
	logic [PIPE_DEPTH-1:0] en;

	genvar k;
	generate
		for (k = 0; k < PIPE_DEPTH; k++) begin : g_en
			if (k == PIPE_DEPTH - 1) begin : g_last
				assign en[k] = ~vld_s[k] | m_tready;
			end else begin : g_mid
				assign en[k] = ~vld_s[k] | en[k+1];
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int i = 0; i < PIPE_DEPTH; i++) begin
				if (en[i]) begin
					vld_s[i] <= (i == 0) ? s_tvalid : vld_s[(i == 0) ? 0 : i-1];
				end
			end
		end
	end

	assign s_tready = en[0];

	// input unpack
	logic [13:0] a_pos_x, a_pos_y, b_pos_x, b_pos_y;
	logic [5:0]  a_radius, b_radius;
	vel4_t       vel_in;
	assign a_pos_x   = s_tdata[13:0];
	assign a_pos_y   = s_tdata[27:14];
	assign a_radius  = s_tdata[33:28];
	assign vel_in.ax = s_tdata[49:34];
	assign vel_in.ay = s_tdata[65:50];
	assign b_pos_x   = s_tdata[79:66];
	assign b_pos_y   = s_tdata[93:80];
	assign b_radius  = s_tdata[99:94];
	assign vel_in.bx = s_tdata[115:100];
	assign vel_in.by = s_tdata[131:116];

	// s1: position and velocity differences, mass sum
	logic signed [14:0] dx_s1, dy_s1;
	logic signed [16:0] dvx_s1, dvy_s1;
	logic [5:0]         ma_s1, mb_s1;
	logic [6:0]         msum_s1;
	vel4_t              vel_s1;
	always_ff @(posedge clk) begin
		if (en[0]) begin
			dx_s1   <= $signed({1'b0, a_pos_x}) - $signed({1'b0, b_pos_x});
			dy_s1   <= $signed({1'b0, a_pos_y}) - $signed({1'b0, b_pos_y});
			dvx_s1  <= 17'(vel_in.ax) - 17'(vel_in.bx);
			dvy_s1  <= 17'(vel_in.ay) - 17'(vel_in.by);
			ma_s1   <= a_radius;
			mb_s1   <= b_radius;
			msum_s1 <= {1'b0, a_radius} + {1'b0, b_radius};
			vel_s1  <= vel_in;
		end
	end

	// s2: squares, look-ahead vector, dot product terms
	logic signed [29:0] dxsq_w, dysq_w;
	logic [13:0]        msq_w;
	logic signed [8:0]  f_sg;
	logic signed [23:0] lx_w, ly_w;
	logic signed [31:0] pdx_w, pdy_w;
	assign dxsq_w = dx_s1 * dx_s1;
	assign dysq_w = dy_s1 * dy_s1;
	assign msq_w  = msum_s1 * msum_s1;
	assign f_sg   = $signed({1'b0, frame_rate_q});
	assign lx_w   = f_sg * dx_s1 + 24'(dvx_s1);
	assign ly_w   = f_sg * dy_s1 + 24'(dvy_s1);
	assign pdx_w  = dvx_s1 * dx_s1;
	assign pdy_w  = dvy_s1 * dy_s1;

	logic [27:0]        dx2_s2, dy2_s2;
	logic [21:0]        rs2_s2;
	logic signed [23:0] lx_s2, ly_s2;
	logic signed [31:0] pdx_s2, pdy_s2;
	logic [15:0]        f2_s2;
	logic signed [14:0] dx_s2, dy_s2;
	logic [5:0]         ma_s2, mb_s2;
	logic [6:0]         msum_s2;
	vel4_t              vel_s2;
	always_ff @(posedge clk) begin
		if (en[1]) begin
			dx2_s2  <= dxsq_w[27:0];
			dy2_s2  <= dysq_w[27:0];
			rs2_s2  <= {msq_w, 8'd0};
			lx_s2   <= lx_w;
			ly_s2   <= ly_w;
			pdx_s2  <= pdx_w;
			pdy_s2  <= pdy_w;
			f2_s2   <= frame_rate_q * frame_rate_q;
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			ma_s2   <= ma_s1;
			mb_s2   <= mb_s1;
			msum_s2 <= msum_s1;
			vel_s2  <= vel_s1;
		end
	end

	// s3: distance squared, look-ahead squares, dot product
	logic signed [47:0] lxsq_w, lysq_w;
	assign lxsq_w = lx_s2 * lx_s2;
	assign lysq_w = ly_s2 * ly_s2;

	logic [28:0]        d2_s3;
	logic [44:0]        lx2_s3, ly2_s3;
	logic signed [32:0] dot_s3;
	logic [15:0]        f2_s3;
	logic [21:0]        rs2_s3;
	logic signed [14:0] dx_s3, dy_s3;
	logic [5:0]         ma_s3, mb_s3;
	logic [6:0]         msum_s3;
	vel4_t              vel_s3;
	always_ff @(posedge clk) begin
		if (en[2]) begin
			d2_s3   <= {1'b0, dx2_s2} + {1'b0, dy2_s2};
			lx2_s3  <= lxsq_w[44:0];
			ly2_s3  <= lysq_w[44:0];
			dot_s3  <= 33'(pdx_s2) + 33'(pdy_s2);
			f2_s3   <= f2_s2;
			rs2_s3  <= rs2_s2;
			dx_s3   <= dx_s2;
			dy_s3   <= dy_s2;
			ma_s3   <= ma_s2;
			mb_s3   <= mb_s2;
			msum_s3 <= msum_s2;
			vel_s3  <= vel_s2;
		end
	end

	// s4: tests, scaled distance, magnitude of dot*d
	logic [32:0] adot_w;
	logic [14:0] adx_w, ady_w;
	logic [44:0] now_w;
	assign adot_w = dot_s3[32] ? 33'(-dot_s3) : 33'(dot_s3);
	assign adx_w  = dx_s3[14] ? 15'(-dx_s3) : 15'(dx_s3);
	assign ady_w  = dy_s3[14] ? 15'(-dy_s3) : 15'(dy_s3);
	assign now_w  = f2_s3 * d2_s3;

	logic        ovl_s4, coin_s4;
	logic [45:0] now_s4, after_s4;
	logic [42:0] pdx_s4, pdy_s4;
	logic        negx_s4, negy_s4;
	logic [21:0] d2_s4;
	logic [5:0]  ma_s4, mb_s4;
	logic [6:0]  msum_s4;
	vel4_t       vel_s4;
	always_ff @(posedge clk) begin
		if (en[3]) begin
			ovl_s4   <= (d2_s3 < {7'd0, rs2_s3});
			coin_s4  <= (d2_s3 == '0);
			now_s4   <= {1'b0, now_w};
			after_s4 <= {1'b0, lx2_s3} + {1'b0, ly2_s3};
			// within the resolved range |dot| < 2^28 and |d| < 2^11
			pdx_s4   <= adot_w[28:0] * adx_w[13:0];
			pdy_s4   <= adot_w[28:0] * ady_w[13:0];
			negx_s4  <= dot_s3[32] ^ dx_s3[14];
			negy_s4  <= dot_s3[32] ^ dy_s3[14];
			d2_s4    <= d2_s3[21:0];
			ma_s4    <= ma_s3;
			mb_s4    <= mb_s3;
			msum_s4  <= msum_s3;
			vel_s4   <= vel_s3;
		end
	end

	// s5: status, numerators and denominator
	logic [49:0] nax_w, nay_w, nbx_w, nby_w;
	logic [28:0] den_w;
	status_t     status_w;
	assign nax_w = pdx_s4 * {mb_s4, 1'b0};
	assign nay_w = pdy_s4 * {mb_s4, 1'b0};
	assign nbx_w = pdx_s4 * {ma_s4, 1'b0};
	assign nby_w = pdy_s4 * {ma_s4, 1'b0};
	assign den_w = msum_s4 * d2_s4;

	always_comb begin
		priority if (!ovl_s4) begin
			status_w = ST_APART;
		end else if (coin_s4) begin
			status_w = ST_COINCIDENT;
		end else if (!(after_s4 < now_s4)) begin
			status_w = ST_SEPARATING;
		end else begin
			status_w = ST_RESOLVED;
		end
	end

	logic [NUM_W-1:0] nax_s5, nay_s5, nbx_s5, nby_s5;
	logic [DEN_W-1:0] den_s5;
	side_t            side_s5;
	always_ff @(posedge clk) begin
		if (en[4]) begin
			nax_s5         <= nax_w[NUM_W-1:0];
			nay_s5         <= nay_w[NUM_W-1:0];
			nbx_s5         <= nbx_w[NUM_W-1:0];
			nby_s5         <= nby_w[NUM_W-1:0];
			den_s5         <= den_w;
			side_s5.vel    <= vel_s4;
			side_s5.status <= status_w;
			side_s5.neg_x  <= negx_s4;
			side_s5.neg_y  <= negy_s4;
		end
	end

	// four divider lanes
	logic [DIV_STEPS-1:0] en_div;
	logic [DIV_STEPS-1:0] qax, qay, qbx, qby;
	assign en_div = en[STG_OUT-1:DIV_BASE];

	dpec_div u_div_ax (.clk(clk), .en(en_div), .num(nax_s5), .den(den_s5), .quo(qax));
	dpec_div u_div_ay (.clk(clk), .en(en_div), .num(nay_s5), .den(den_s5), .quo(qay));
	dpec_div u_div_bx (.clk(clk), .en(en_div), .num(nbx_s5), .den(den_s5), .quo(qbx));
	dpec_div u_div_by (.clk(clk), .en(en_div), .num(nby_s5), .den(den_s5), .quo(qby));

	// sideband alongside the divider steps
	side_t side_dv [DIV_STEPS];
	generate
		for (k = 0; k < DIV_STEPS; k++) begin : g_side
			always_ff @(posedge clk) begin
				if (en[DIV_BASE+k]) begin
					side_dv[k] <= (k == 0) ? side_s5 : side_dv[(k == 0) ? 0 : k-1];
				end
			end
		end
	endgenerate

	// output: apply sign, exchange, saturate
	side_t              side_l;
	logic signed [18:0] dax, day, dbx, dby;
	logic signed [19:0] sax, say, sbx, sby;
	assign side_l = side_dv[DIV_STEPS-1];
	assign dax = side_l.neg_x ? -$signed({1'b0, qax}) : $signed({1'b0, qax});
	assign day = side_l.neg_y ? -$signed({1'b0, qay}) : $signed({1'b0, qay});
	assign dbx = side_l.neg_x ? -$signed({1'b0, qbx}) : $signed({1'b0, qbx});
	assign dby = side_l.neg_y ? -$signed({1'b0, qby}) : $signed({1'b0, qby});
	assign sax = 20'(side_l.vel.ax) - 20'(dax);
	assign say = 20'(side_l.vel.ay) - 20'(day);
	assign sbx = 20'(side_l.vel.bx) + 20'(dbx);
	assign sby = 20'(side_l.vel.by) + 20'(dby);

	function automatic vel_t sat16(input logic signed [19:0] v);
		vel_t r;
		if (v > 20'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -20'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	vel4_t   vel_q;
	status_t status_q;
	always_ff @(posedge clk) begin
		if (en[STG_OUT]) begin
			status_q <= side_l.status;
			if (side_l.status == ST_RESOLVED) begin
				vel_q.ax <= sat16(sax);
				vel_q.ay <= sat16(say);
				vel_q.bx <= sat16(sbx);
				vel_q.by <= sat16(sby);
			end else begin
				vel_q <= side_l.vel;
			end
		end
	end

	assign m_tvalid = vld_s[STG_OUT];
	assign m_tdata  = {vel_q.by, vel_q.bx, vel_q.ay, vel_q.ax};
	assign m_tuser  = status_q;

endmodule
`default_nettype wire
